### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the slot message buffer.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: implication");

// Check that a condition implies another in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### hw/rtl/smb_pkg.sv
// Shared types and constants of the slot message buffer.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package smb_pkg;

    // Operation codes carried on the action field
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted input item
        logic exec;      // apply the store or read to the slot state
        logic load_out;  // move the staged result into the output register
    } smb_cmd_t;

endpackage

### hw/rtl/smb_controller.sv
// Sequencing state machine of the slot message buffer.
// Depends on smb_pkg for the command struct.
`timescale 1ns / 1ps

module smb_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output smb_pkg::smb_cmd_t cmd
);
    import smb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load_ok;

    // Take a new item only when no item is in flight
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Load the output register once it is empty or being drained
    assign load_ok = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.capture  = in_valid && in_ready;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.load_out = load_ok;
    end

    // Advance through capture, execute and load
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_ok)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_ok)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/smb_datapath.sv
// Slot store, search logic, flags and output register of the slot message buffer.
// Depends on smb_pkg for the action codes and the command struct.
`timescale 1ns / 1ps

module smb_datapath
#(
    parameter int SLOTS         = 10,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  smb_pkg::smb_cmd_t cmd,
    input  logic              action,
    input  logic [31:0]       payload,
    output logic              read_valid,
    output logic [31:0]       read_payload,
    output logic              stored,
    output logic              available,
    output logic              overload,
    output logic [3:0]        message_count
);
    import smb_pkg::*;

    // Stored width: the input field carries at most 32 bits
    localparam int DW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
    localparam int IW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);

    // Index of the single set bit of a one-hot vector
    function automatic logic [IW-1:0] oh_to_idx(input logic [SLOTS-1:0] oh);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (oh[i])
                idx = idx | IW'(i);
        end
        return idx;
    endfunction

    // Captured input item
    logic          act_reg;
    logic [DW-1:0] data_reg;

    // Slot state and flags
    logic [SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic             slot0_written_reg, slot0_written_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [PW-1:0]    count_reg, count_next;
    logic             avail_reg, avail_next;
    logic             ovl_reg, ovl_next;

    // Staged result, waiting for the memory read data
    logic res_valid_reg, res_valid_next;
    logic res_stored_reg, res_stored_next;
    logic res_zero_reg, res_zero_next;

    // Payload memory
    logic [DW-1:0] mem [SLOTS];
    logic [DW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    // Output register
    logic        read_valid_reg;
    logic [31:0] read_payload_reg;
    logic        stored_reg;
    logic        available_reg;
    logic        overload_reg;
    logic [3:0]  count_out_reg;

    // Search signals
    logic [SLOTS-1:0] lower_mask;
    logic [SLOTS-1:0] upper_vec;
    logic [SLOTS-1:0] search_vec;
    logic [SLOTS-1:0] hit_oh;
    logic [SLOTS-1:0] free_vec;
    logic [SLOTS-1:0] free_oh;
    logic             hit_found;
    logic             free_found;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    free_idx;
    logic [PW+3:0]    count_ext;

    // Mask off slots below the read pointer
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            lower_mask[i] = (PW'(i) < ptr_reg);
    end

    // Pick the first valid slot at or above the pointer, else wrap to the lowest valid slot
    assign upper_vec  = slot_valid_reg & ~lower_mask;
    assign search_vec = (|upper_vec) ? upper_vec : slot_valid_reg;
    assign hit_oh     = search_vec & (~search_vec + SLOTS'(1));
    assign hit_found  = |slot_valid_reg;
    assign hit_idx    = oh_to_idx(hit_oh);

    // Pick the lowest free slot
    assign free_vec   = ~slot_valid_reg;
    assign free_oh    = free_vec & (~free_vec + SLOTS'(1));
    assign free_found = |free_vec;
    assign free_idx   = oh_to_idx(free_oh);

    // Apply the store or read
    always_comb
    begin
        slot_valid_next    = slot_valid_reg;
        slot0_written_next = slot0_written_reg;
        ptr_next           = ptr_reg;
        count_next         = count_reg;
        avail_next         = avail_reg;
        ovl_next           = ovl_reg;
        res_valid_next     = res_valid_reg;
        res_stored_next    = res_stored_reg;
        res_zero_next      = res_zero_reg;
        mem_we             = 1'b0;
        wr_addr            = free_idx;
        rd_addr            = '0;
        if (cmd.exec)
        begin
            if (act_reg == ACT_STORE)
            begin
                avail_next     = 1'b1;
                res_valid_next = 1'b0;
                res_zero_next  = 1'b1;
                if (free_found)
                begin
                    slot_valid_next = slot_valid_reg | free_oh;
                    mem_we          = 1'b1;
                    count_next      = count_reg + PW'(1);
                    ovl_next        = 1'b0;
                    res_stored_next = 1'b1;
                    if (free_idx == '0)
                        slot0_written_next = 1'b1;
                end
                else
                begin
                    ovl_next        = 1'b1;
                    res_stored_next = 1'b0;
                end
            end
            else
            begin
                res_stored_next = 1'b0;
                if (hit_found)
                begin
                    slot_valid_next = slot_valid_reg & ~hit_oh;
                    if (count_reg != '0)
                        count_next = count_reg - PW'(1);
                    ptr_next       = PW'(hit_idx) + PW'(1);
                    rd_addr        = hit_idx;
                    res_valid_next = 1'b1;
                    res_zero_next  = 1'b0;
                end
                else
                begin
                    // Empty read: return slot 0's stale contents, or zero if slot 0 was never written
                    ptr_next       = '0;
                    avail_next     = 1'b0;
                    ovl_next       = 1'b0;
                    rd_addr        = '0;
                    res_valid_next = 1'b0;
                    res_zero_next  = !slot0_written_reg;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg    <= '0;
            slot0_written_reg <= 1'b0;
            ptr_reg           <= '0;
            count_reg         <= '0;
            avail_reg         <= 1'b0;
            ovl_reg           <= 1'b0;
        end
        else
        begin
            slot_valid_reg    <= slot_valid_next;
            slot0_written_reg <= slot0_written_next;
            ptr_reg           <= ptr_next;
            count_reg         <= count_next;
            avail_reg         <= avail_next;
            ovl_reg           <= ovl_next;
        end
    end

    // Latch the input item on its transfer; stage the result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            data_reg <= payload[DW-1:0];
        end
        res_valid_reg  <= res_valid_next;
        res_stored_reg <= res_stored_next;
        res_zero_reg   <= res_zero_next;
    end

    // Write and read the payload memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= data_reg;
        if (cmd.exec)
            rd_data_reg <= mem[rd_addr];
    end

    // Load the output register
    assign count_ext = {4'b0000, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_valid_reg   <= res_valid_reg;
            read_payload_reg <= res_zero_reg ? 32'd0 : 32'(rd_data_reg);
            stored_reg       <= res_stored_reg;
            available_reg    <= avail_reg;
            overload_reg     <= ovl_reg;
            count_out_reg    <= count_ext[3:0];
        end
    end

    assign read_valid    = read_valid_reg;
    assign read_payload  = read_payload_reg;
    assign stored        = stored_reg;
    assign available     = available_reg;
    assign overload      = overload_reg;
    assign message_count = count_out_reg;

endmodule

### hw/rtl/slot_message_buffer.sv
// Each item passes through capture, execute and load; no new item is taken before
// its load. Capture latches the input, execute applies it to the slots and reads the
// payload memory, and load moves the result to the output register once it is free.
// A new item is taken while the previous result waits in the output register.
// Reset (rst_n, asynchronous): all slots empty, pointer, count and flags cleared.
// Top level of the slot message buffer; depends on smb_pkg, the controller,
// the datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slot_message_buffer
#(
    parameter int SLOTS         = 10,
    parameter int PAYLOAD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] payload,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        read_valid,
    output logic [31:0] read_payload,
    output logic        stored,
    output logic        available,
    output logic        overload,
    output logic [3:0]  message_count
);
    import smb_pkg::*;

    smb_cmd_t cmd;

    // Sequence each item
    smb_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold the slots and produce the result
    smb_datapath
    #(
        .SLOTS         (SLOTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .payload       (payload),
        .read_valid    (read_valid),
        .read_payload  (read_payload),
        .stored        (stored),
        .available     (available),
        .overload      (overload),
        .message_count (message_count)
    );

    // One item in flight: no transfer in the cycle after one is taken
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    // A result is never both a read hit and a store
    `ASSERT_IMPLIES(a_read_or_store, clk, rst_n, out_valid && read_valid, !stored)
    // Overload only arises after a store, which also sets available
    `ASSERT_IMPLIES(a_overload_avail, clk, rst_n, out_valid && overload, available)
    // A successful store always leaves the buffer marked available
    `ASSERT_IMPLIES(a_stored_avail, clk, rst_n, out_valid && stored, available)

endmodule

### dv/tb_slot_message_buffer.sv
// Self-checking testbench for slot_message_buffer: directed and random store/read traffic.
// Predicts every result in step with each input transfer; depends on smb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_slot_message_buffer;

    import smb_pkg::*;

    localparam int SLOTS         = 10;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDLE_PCT      = 21;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 825;
    localparam int DRAIN_CYCLES  = 12;

    typedef struct packed {
        logic        act;
        logic [31:0] data;
    } msg_item_t;

    typedef struct packed {
        logic        rd_valid;
        logic [31:0] rd_data;
        logic        was_stored;
        logic        avail;
        logic        ovl;
        logic [3:0]  cnt;
    } msg_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        action        = ACT_STORE;
    logic [31:0] payload       = '0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        read_valid;
    logic [31:0] read_payload;
    logic        stored;
    logic        available;
    logic        overload;
    logic [3:0]  message_count;

    // Stimulus waiting to be driven and results waiting to arrive
    msg_item_t   pending_items[$];
    msg_result_t expected_results[$];

    // Mirror of the buffer contents and flags
    bit          slot_used [SLOTS];
    bit [31:0]   slot_data [SLOTS];
    int          rd_ptr;
    int          msg_total;
    bit          buf_avail;
    bit          buf_ovl;

    int          errors;
    int          cyc;
    int          quiet_cycles;
    bit          in_taken;
    int          n_stores;
    int          n_dropped;
    int          n_hits;
    int          n_empty_reads;
    int          n_checked;

    slot_message_buffer #(
        .SLOTS         (SLOTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_valid    (read_valid),
        .read_payload  (read_payload),
        .stored        (stored),
        .available     (available),
        .overload      (overload),
        .message_count (message_count)
    );

    always #10 clk = ~clk;

    // Apply one store or read to the mirror and return the result it gives
    function automatic msg_result_t apply_item(logic act, logic [31:0] data);
        msg_result_t r;
        int          hit;
        int          i;
        r   = '0;
        hit = SLOTS;
        if (act == ACT_STORE)
        begin
            n_stores++;
            buf_avail = 1'b1;
            for (i = SLOTS - 1; i >= 0; i--)
                if (!slot_used[i])
                    hit = i;
            if (hit < SLOTS)
            begin
                slot_used[hit] = 1'b1;
                slot_data[hit] = data;
                msg_total++;
                buf_ovl = 1'b0;
                r.was_stored = 1'b1;
            end
            else
            begin
                buf_ovl = 1'b1;
                n_dropped++;
            end
        end
        else
        begin
            // search upward from the pointer, then once more from slot 0
            for (i = SLOTS - 1; i >= rd_ptr; i--)
                if (slot_used[i])
                    hit = i;
            if (hit == SLOTS)
                for (i = SLOTS - 1; i >= 0; i--)
                    if (slot_used[i])
                        hit = i;
            if (hit < SLOTS)
            begin
                r.rd_valid = 1'b1;
                r.rd_data  = slot_data[hit];
                slot_used[hit] = 1'b0;
                if (msg_total > 0)
                    msg_total--;
                rd_ptr = hit + 1;
                n_hits++;
            end
            else
            begin
                rd_ptr    = 0;
                buf_avail = 1'b0;
                buf_ovl   = 1'b0;
                r.rd_data = slot_data[0];
                n_empty_reads++;
            end
        end
        r.avail = buf_avail;
        r.ovl   = buf_ovl;
        r.cnt   = msg_total[3:0];
        return r;
    endfunction

    task automatic note_error(string what, msg_result_t want, msg_result_t got);
        errors++;
        if (errors <= 10)
            $display({"%0t: %s: expected rv=%0b rp=%h st=%0b av=%0b ov=%0b cnt=%0d,",
                      " got rv=%0b rp=%h st=%0b av=%0b ov=%0b cnt=%0d"},
                     $realtime, what, want.rd_valid, want.rd_data, want.was_stored,
                     want.avail, want.ovl, want.cnt, got.rd_valid, got.rd_data,
                     got.was_stored, got.avail, got.ovl, got.cnt);
    endtask

    task automatic push_item(logic act, logic [31:0] data);
        msg_item_t it;
        it.act  = act;
        it.data = data;
        pending_items.push_back(it);
    endtask

    // Drive inputs on the falling edge; hold an offered item until its transfer
    always @(negedge clk)
    begin
        bit calm;
        calm = (cyc >= 1500 && cyc < 2500);
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    action   <= pending_items[0].act;
                    payload  <= pending_items[0].data;
                    void'(pending_items.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Sample transfers on the rising edge: predict on input, check on output
    always @(posedge clk)
    begin
        msg_result_t got;
        msg_result_t want;
        cyc <= cyc + 1;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_results.push_back(apply_item(action, payload));
            if (out_valid && out_ready)
            begin
                got = '{read_valid, read_payload, stored, available, overload, message_count};
                n_checked++;
                if (expected_results.size() == 0)
                    note_error("result with nothing expected", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_error("result mismatch", want, got);
                end
            end
            // watchdog on cycles with no transfer at all
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
                $display("tb_slot_message_buffer NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int          n;
        int          burst;
        int          store_pct;
        logic [31:0] data;
        logic        act;

        // Read from an empty buffer straight after reset
        push_item(ACT_READ, 32'hDEAD_BEEF);
        // Fill every slot, with the payload extremes among the values
        push_item(ACT_STORE, 32'hFFFF_FFFF);
        push_item(ACT_STORE, 32'h0000_0000);
        push_item(ACT_STORE, 32'hAAAA_AAAA);
        push_item(ACT_STORE, 32'h5555_5555);
        for (n = 4; n < SLOTS; n++)
            push_item(ACT_STORE, $urandom);
        // Store into a full buffer: dropped, overload set
        push_item(ACT_STORE, 32'h1234_5678);
        // Drain slots 0..8 with junk on the payload lines
        for (n = 0; n < SLOTS - 1; n++)
            push_item(ACT_READ, $urandom);
        // Refill slot 0 (clears overload), read slot 9, then wrap from past the end
        push_item(ACT_STORE, 32'h8000_0001);
        push_item(ACT_READ, 32'h0);
        push_item(ACT_READ, 32'hFFFF_FFFF);
        // Empty read returns stale slot 0 contents
        push_item(ACT_READ, 32'h0);

        // Random bursts, each leaning towards stores, reads or a balance
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            burst = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
                0:       store_pct = 85;
                1:       store_pct = 20;
                default: store_pct = 50;
            endcase
            repeat (burst)
            begin
                act = ($urandom_range(0, 99) < store_pct) ? ACT_STORE : ACT_READ;
                case ($urandom_range(0, 9))
                    0:       data = 32'h0;
                    1:       data = 32'hFFFF_FFFF;
                    default: data = $urandom;
                endcase
                push_item(act, data);
                n++;
            end
        end

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to transfer and every result to arrive
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        errors += expected_results.size();
        $display("checked %0d results: %0d stores (%0d dropped on a full buffer), %0d reads",
                 n_checked, n_stores, n_dropped, n_hits + n_empty_reads);
        $display("reads returning a message: %0d, reads of an empty buffer: %0d, errors: %0d",
                 n_hits, n_empty_reads, errors);
        if (errors == 0)
            $display("tb_slot_message_buffer OK");
        else
            $display("tb_slot_message_buffer NOT OK");
        $finish;
    end

endmodule
